// File: rtl/dwr_pkg.sv
// package for draw_without_replacement: sizes, register indexes, controller types
`timescale 1ns / 1ps
package dwr_pkg;

  localparam int MAX_OUTCOMES = 256;
  localparam int ROW_W        = 16;
  localparam int NROWS        = MAX_OUTCOMES / ROW_W;
  localparam int ROW_IW       = $clog2(NROWS);
  localparam int BIT_IW       = $clog2(ROW_W);
  localparam int POS_W        = $clog2(MAX_OUTCOMES);
  localparam int CNT_W        = $clog2(MAX_OUTCOMES + 1);
  localparam int PC_W         = $clog2(ROW_W + 1);
  localparam int VAL_W        = 16;
  localparam int RW_W         = 31;
  localparam int DC_W         = $clog2(RW_W);
  localparam int ADDR_W       = 2;
  localparam int RESET_SPAN   = 2;

  localparam logic [ADDR_W-1:0] REG_RANGE_LOW    = ADDR_W'(0);
  localparam logic [ADDR_W-1:0] REG_RANGE_HIGH   = ADDR_W'(1);
  localparam logic [ADDR_W-1:0] REG_ALLOW_REPEAT = ADDR_W'(2);

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_ROWS,
    ST_BITS,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic emit_invalid;
    logic div_step;
    logic row_step;
    logic bit_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic invalid;
    logic div_last;
    logic row_hit;
    logic bit_hit;
  } sts_t;

endpackage

// File: rtl/dwr_ctrl.sv
// controller state machine for the draw sequence
`timescale 1ns / 1ps
module dwr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  dwr_pkg::sts_t sts,
  output dwr_pkg::cmd_t cmd,
  output logic          busy
);
  import dwr_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = sts.invalid ? ST_IDLE : ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_last) state_nxt = ST_ROWS;
      end
      ST_ROWS: begin
        if (sts.row_hit) state_nxt = ST_BITS;
      end
      ST_BITS: begin
        if (sts.bit_hit) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_CHECK: begin
        cmd.emit_invalid = sts.invalid;
        cmd.prep         = !sts.invalid;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_ROWS: begin
        cmd.row_step = 1'b1;
      end
      ST_BITS: begin
        cmd.bit_step = 1'b1;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// File: rtl/dwr_dp.sv
// datapath: registers, pool bitmap, serial modulo, rank select, result register
`timescale 1ns / 1ps
module dwr_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dwr_pkg::cmd_t                 cmd,
  output dwr_pkg::sts_t                 sts,
  input  logic [dwr_pkg::RW_W-1:0]      in_random_word,
  input  logic                          in_dry_run,
  input  logic                          cfg_we,
  input  logic [dwr_pkg::ADDR_W-1:0]    cfg_addr,
  input  logic [dwr_pkg::VAL_W-1:0]     cfg_wdata,
  output logic                          out_valid,
  output logic signed [dwr_pkg::VAL_W-1:0] out_outcome,
  output logic                          out_status
);
  import dwr_pkg::*;

  logic signed [VAL_W-1:0] range_low_r;
  logic signed [VAL_W-1:0] range_high_r;
  logic                    allow_repeat_r;
  logic [ROW_W-1:0]        map_r [NROWS];
  logic [CNT_W-1:0]        count_r;
  logic                    pending_r;

  logic [RW_W-1:0]         rnd_r;
  logic                    dry_r;
  logic [DC_W-1:0]         div_cnt_r;
  logic [POS_W-1:0]        rem_r;
  logic [POS_W-1:0]        seen_r;
  logic [ROW_IW-1:0]       row_r;
  logic [BIT_IW-1:0]       bidx_r;

  logic                    out_valid_r;
  logic signed [VAL_W-1:0] outcome_r;
  logic                    status_r;

  logic signed [VAL_W:0]   diff;
  logic                    invalid;
  logic [CNT_W-1:0]        span;
  logic [ROW_W-1:0]        fill [NROWS];
  logic                    do_refill;
  logic [CNT_W-1:0]        shifted;
  logic [ROW_W-1:0]        cur_row;
  logic [PC_W-1:0]         pc;
  logic [CNT_W-1:0]        seen_plus;
  logic [POS_W-1:0]        offset;

  function automatic logic [ROW_W-1:0] row_fill(input logic [CNT_W-1:0] n, input int r);
    logic [CNT_W-1:0] base;
    logic [CNT_W:0]   top;
    logic [ROW_W-1:0] m;
    base = CNT_W'(r * ROW_W);
    top  = (CNT_W + 1)'((r + 1) * ROW_W);
    if ({1'b0, n} >= top) begin
      m = '1;
    end else if (n > base) begin
      m = ~({ROW_W{1'b1}} << (n - base));
    end else begin
      m = '0;
    end
    return m;
  endfunction

  function automatic logic [PC_W-1:0] popcount(input logic [ROW_W-1:0] v);
    logic [PC_W-1:0] c;
    c = '0;
    for (int i = 0; i < ROW_W; i++) begin
      c = c + PC_W'(v[i]);
    end
    return c;
  endfunction

  // range check
  assign diff    = {range_high_r[VAL_W-1], range_high_r} - {range_low_r[VAL_W-1], range_low_r};
  assign invalid = (diff <= 0) || (diff > (VAL_W + 1)'(MAX_OUTCOMES - 1));
  assign span    = CNT_W'(diff) + CNT_W'(1);

  always_comb begin
    for (int r = 0; r < NROWS; r++) begin
      fill[r] = row_fill(span, r);
    end
  end

  assign do_refill = pending_r || (count_r == '0);
  assign shifted   = {rem_r, rnd_r[div_cnt_r]};
  assign cur_row   = map_r[row_r];
  assign pc        = popcount(cur_row);
  assign seen_plus = {1'b0, seen_r} + CNT_W'(pc);
  assign offset    = {row_r, bidx_r};

  assign sts.invalid  = invalid;
  assign sts.div_last = (div_cnt_r == '0);
  assign sts.row_hit  = seen_plus > {1'b0, rem_r};
  assign sts.bit_hit  = cur_row[bidx_r] && (seen_r == rem_r);

  // configuration registers and pool state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r    <= '0;
      range_high_r   <= VAL_W'(1);
      allow_repeat_r <= 1'b0;
      pending_r      <= 1'b0;
      count_r        <= CNT_W'(RESET_SPAN);
      for (int r = 0; r < NROWS; r++) begin
        map_r[r] <= row_fill(CNT_W'(RESET_SPAN), r);
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_RANGE_LOW: begin
            range_low_r <= cfg_wdata;
            pending_r   <= 1'b1;
          end
          REG_RANGE_HIGH: begin
            range_high_r <= cfg_wdata;
            pending_r    <= 1'b1;
          end
          REG_ALLOW_REPEAT: begin
            allow_repeat_r <= cfg_wdata[0];
          end
          default: begin
          end
        endcase
      end
      if (cmd.prep && do_refill) begin
        for (int r = 0; r < NROWS; r++) begin
          map_r[r] <= fill[r];
        end
        count_r   <= span;
        pending_r <= 1'b0;
      end
      if (cmd.finish && !allow_repeat_r && !dry_r) begin
        map_r[row_r][bidx_r] <= 1'b0;
        count_r              <= count_r - CNT_W'(1);
      end
    end
  end

  // per-transaction working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rnd_r <= in_random_word;
      dry_r <= in_dry_run;
    end
    if (cmd.prep) begin
      rem_r     <= '0;
      div_cnt_r <= DC_W'(RW_W - 1);
      seen_r    <= '0;
      row_r     <= '0;
      bidx_r    <= '0;
    end
    if (cmd.div_step) begin
      if (shifted >= count_r) begin
        rem_r <= POS_W'(shifted - count_r);
      end else begin
        rem_r <= shifted[POS_W-1:0];
      end
      div_cnt_r <= div_cnt_r - DC_W'(1);
    end
    if (cmd.row_step && !sts.row_hit) begin
      seen_r <= seen_plus[POS_W-1:0];
      row_r  <= row_r + ROW_IW'(1);
    end
    if (cmd.bit_step && !sts.bit_hit) begin
      if (cur_row[bidx_r]) seen_r <= seen_r + POS_W'(1);
      bidx_r <= bidx_r + BIT_IW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_invalid || cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_invalid) begin
      outcome_r <= '0;
      status_r  <= STATUS_INVALID;
    end else if (cmd.finish) begin
      outcome_r <= range_low_r + $signed({{(VAL_W - POS_W){1'b0}}, offset});
      status_r  <= STATUS_OK;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_outcome = outcome_r;
  assign out_status  = status_r;

endmodule

// File: rtl/draw_without_replacement.sv
// top level: random draw without replacement from a configurable outcome range
`timescale 1ns / 1ps
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+------------------------------
//  input    | in_random_word, in_dry_run              | start high and busy low
//  result   | out_outcome, out_status                 | out_valid one-cycle strobe
//  config   | cfg_addr, cfg_wdata                     | cfg_we high, no wait
//
//  an invalid range gives its result from the check state, through the result register
//  a valid draw is busy for a setup state, the serial modulo, a row scan over up to 16 rows,
//  a bit scan over up to 16 bits of one row and an update state; the result is registered
//  busy stays high until the draw finishes; one draw is in flight at a time
//  synchronous reset restores range 0..1 with both outcomes available
//  results cannot be stalled
module draw_without_replacement (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [dwr_pkg::RW_W-1:0]         in_random_word,
  input  logic                             in_dry_run,
  output logic                             out_valid,
  output logic signed [dwr_pkg::VAL_W-1:0] out_outcome,
  output logic                             out_status,
  input  logic                             cfg_we,
  input  logic [dwr_pkg::ADDR_W-1:0]       cfg_addr,
  input  logic [dwr_pkg::VAL_W-1:0]        cfg_wdata
);
  import dwr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dwr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  dwr_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_random_word (in_random_word),
    .in_dry_run     (in_dry_run),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_outcome    (out_outcome),
    .out_status     (out_status)
  );

endmodule

// File: dv/draw_without_replacement_checker.sv
// checker for draw_without_replacement: models the outcome pool and compares every draw result
`timescale 1ns / 1ps
module draw_without_replacement_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             busy,
  input  logic [dwr_pkg::RW_W-1:0]         in_random_word,
  input  logic                             in_dry_run,
  input  logic                             out_valid,
  input  logic signed [dwr_pkg::VAL_W-1:0] out_outcome,
  input  logic                             out_status,
  input  logic                             cfg_we,
  input  logic [dwr_pkg::ADDR_W-1:0]       cfg_addr,
  input  logic [dwr_pkg::VAL_W-1:0]        cfg_wdata,
  output int                               fails,
  output int                               pending
);
  import dwr_pkg::*;

  typedef struct packed {
    logic signed [VAL_W-1:0] outcome;
    logic                    status;
  } draw_t;

  draw_t                   draws_due[$];
  logic signed [VAL_W-1:0] range_lo;
  logic signed [VAL_W-1:0] range_hi;
  logic                    keep_drawn;
  logic [MAX_OUTCOMES-1:0] pool;
  int unsigned             pool_count;
  logic                    refill_due;
  int                      n_fail = 0;

  task automatic fill_pool(input int span);
    int i;
    pool = '0;
    for (i = 0; i < span && i < MAX_OUTCOMES; i++) pool[i] = 1'b1;
    pool_count = i;
  endtask

  task automatic predict_draw(input logic [RW_W-1:0] word, input logic dry,
                              output draw_t res);
    int          span;
    int unsigned pos;
    int unsigned seen;
    int          off;
    bit          found;
    span  = int'(range_hi) - int'(range_lo) + 1;
    seen  = 0;
    off   = 0;
    found = 0;
    if (range_lo >= range_hi || span > MAX_OUTCOMES) begin
      res.outcome = '0;
      res.status  = STATUS_INVALID;
      return;
    end
    if (refill_due || pool_count == 0) begin
      fill_pool(span);
      refill_due = 1'b0;
    end
    pos = word % pool_count;
    for (int i = 0; i < MAX_OUTCOMES; i++) begin
      if (!found && pool[i]) begin
        if (seen == pos) begin
          off   = i;
          found = 1;
        end else begin
          seen++;
        end
      end
    end
    if (found && !keep_drawn && !dry) begin
      pool[off] = 1'b0;
      pool_count--;
    end
    res.outcome = VAL_W'(int'(range_lo) + off);
    res.status  = STATUS_OK;
  endtask

  always @(posedge clk) begin : watch
    draw_t want;
    draw_t got;
    if (!rst_n) begin
      range_lo   = '0;
      range_hi   = 1;
      keep_drawn = 1'b0;
      refill_due = 1'b0;
      fill_pool(RESET_SPAN);
      draws_due.delete();
    end else begin
      if (out_valid) begin
        got.outcome = out_outcome;
        got.status  = out_status;
        if (draws_due.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("unexpected draw result: outcome %0d st %0b", got.outcome, got.status);
        end else begin
          want = draws_due.pop_front();
          if (want.outcome !== got.outcome || want.status !== got.status) begin
            n_fail++;
            if (n_fail <= 10)
              $display("draw mismatch: outcome exp %0d got %0d, st exp %0b got %0b",
                       want.outcome, got.outcome, want.status, got.status);
          end
        end
      end
      if (start && !busy) begin
        predict_draw(in_random_word, in_dry_run, want);
        draws_due.push_back(want);
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_RANGE_LOW: begin
            range_lo   = cfg_wdata;
            refill_due = 1'b1;
          end
          REG_RANGE_HIGH: begin
            range_hi   = cfg_wdata;
            refill_due = 1'b1;
          end
          REG_ALLOW_REPEAT: begin
            keep_drawn = cfg_wdata[0];
          end
          default: begin
          end
        endcase
      end
    end
    fails   <= n_fail;
    pending <= draws_due.size();
  end

endmodule

// File: dv/draw_without_replacement_test.sv
// testbench top for draw_without_replacement: clock, reset, draw and register stimulus, verdict
`timescale 1ns / 1ps
module draw_without_replacement_test;
  import dwr_pkg::*;

  localparam logic [ADDR_W-1:0] REG_SPARE = ADDR_W'(3);
  localparam int ITEMS = 1800;
  localparam int LIMIT = 1000000;
  localparam logic [RW_W-1:0] WORD_MAX = '1;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [RW_W-1:0]         in_random_word;
  logic                    in_dry_run;
  logic                    out_valid;
  logic signed [VAL_W-1:0] out_outcome;
  logic                    out_status;
  logic                    cfg_we;
  logic [ADDR_W-1:0]       cfg_addr;
  logic [VAL_W-1:0]        cfg_wdata;
  int                      fails;
  int                      pending;
  int                      cycle_count = 0;
  int                      drawn = 0;
  int                      cur_lo = 0;
  int                      cur_hi = 1;

  draw_without_replacement DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_random_word (in_random_word),
    .in_dry_run     (in_dry_run),
    .out_valid      (out_valid),
    .out_outcome    (out_outcome),
    .out_status     (out_status),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata)
  );

  draw_without_replacement_checker draw_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_random_word (in_random_word),
    .in_dry_run     (in_dry_run),
    .out_valid      (out_valid),
    .out_outcome    (out_outcome),
    .out_status     (out_status),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .fails          (fails),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : watchdog
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  function automatic logic [RW_W-1:0] rand_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return RW_W'($urandom_range(0, 3));
    if (r < 14) return WORD_MAX - RW_W'($urandom_range(0, 3));
    return RW_W'($urandom());
  endfunction

  // every task starts and ends at a falling edge
  task automatic send_draw(input logic [RW_W-1:0] word, input logic dry, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start          <= 1'b1;
    in_random_word <= word;
    in_dry_run     <= dry;
    @(negedge clk);
    start <= 1'b0;
    while (busy) @(negedge clk);
    @(negedge clk);
    drawn++;
  endtask

  task automatic settle();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0 || busy) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [ADDR_W-1:0] addr, input logic [VAL_W-1:0] data);
    settle();
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (addr == REG_RANGE_LOW) cur_lo = int'($signed(data));
    if (addr == REG_RANGE_HIGH) cur_hi = int'($signed(data));
  endtask

  task automatic set_range(input int lo, input int hi);
    cfg_write(REG_RANGE_LOW, VAL_W'(lo));
    cfg_write(REG_RANGE_HIGH, VAL_W'(hi));
  endtask

  task automatic pick_range(output int lo, output int hi);
    int r;
    int s;
    r = $urandom_range(0, 99);
    s = 0;
    if (r < 55) s = $urandom_range(2, 9);
    else if (r < 70) s = $urandom_range(10, 64);
    else if (r < 80) s = MAX_OUTCOMES;
    else if (r < 84) s = MAX_OUTCOMES + 1;
    if (s > 0) begin
      lo = int'($urandom_range(0, 65536 - s)) - 32768;
      hi = lo + s - 1;
    end else if (r < 92) begin
      lo = int'($urandom_range(0, 65535)) - 32768;
      hi = lo - int'($urandom_range(0, 300));
      if (hi < -32768) hi = -32768;
    end else begin
      lo = int'($urandom_range(0, 65535)) - 32768;
      hi = int'($urandom_range(0, 65535)) - 32768;
    end
  endtask

  initial begin : stimulus
    int  lo;
    int  hi;
    int  span;
    int  n;
    bit  quiet;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_random_word = '0;
    in_dry_run     = 1'b0;
    cfg_we         = 1'b0;
    cfg_addr       = '0;
    cfg_wdata      = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset pool, emptied and refilled
    send_draw('0, 1'b0, 0);
    send_draw(WORD_MAX, 1'b0, 0);
    send_draw(RW_W'(1), 1'b0, 2);
    send_draw('0, 1'b1, 0);
    // unused register index leaves everything alone
    cfg_write(REG_SPARE, '1);
    send_draw(RW_W'(1), 1'b0, 0);
    cfg_write(REG_ALLOW_REPEAT, 16'hfffe | 16'h0001);
    send_draw(WORD_MAX, 1'b0, 0);
    send_draw(WORD_MAX, 1'b0, 1);
    cfg_write(REG_ALLOW_REPEAT, 16'hfffe);
    // full-size ranges at both ends
    set_range(-32768, -32513);
    send_draw(WORD_MAX, 1'b0, 0);
    send_draw('0, 1'b0, 0);
    send_draw(RW_W'(255), 1'b0, 0);
    set_range(32512, 32767);
    send_draw(WORD_MAX, 1'b0, 0);
    send_draw(RW_W'(255), 1'b1, 0);
    // invalid ranges: one too wide, empty, reversed, whole word
    cfg_write(REG_RANGE_LOW, VAL_W'(32511));
    send_draw(RW_W'(7), 1'b0, 0);
    set_range(5, 5);
    send_draw(WORD_MAX, 1'b0, 0);
    set_range(7, -7);
    send_draw('0, 1'b1, 0);
    set_range(-32768, 32767);
    send_draw(RW_W'(3), 1'b0, 0);
    // rewriting the same value still refills
    set_range(-3, 0);
    send_draw(RW_W'(2), 1'b0, 0);
    send_draw(RW_W'(2), 1'b0, 0);
    cfg_write(REG_RANGE_HIGH, VAL_W'(0));
    send_draw(RW_W'(2), 1'b0, 0);

    while (drawn < ITEMS) begin
      if ($urandom_range(0, 99) < 15) begin
        if ($urandom_range(0, 1)) cfg_write(REG_ALLOW_REPEAT, VAL_W'($urandom()));
        else cfg_write(REG_SPARE, VAL_W'($urandom()));
      end else begin
        pick_range(lo, hi);
        if ($urandom_range(0, 1)) begin
          set_range(lo, hi);
        end else begin
          cfg_write(REG_RANGE_HIGH, VAL_W'(hi));
          cfg_write(REG_RANGE_LOW, VAL_W'(lo));
        end
        cfg_write(REG_ALLOW_REPEAT,
                  {(VAL_W - 1)'($urandom()), 1'($urandom_range(0, 99) < 25)});
      end
      span = cur_hi - cur_lo + 1;
      if (cur_lo >= cur_hi || span > MAX_OUTCOMES) n = $urandom_range(2, 5);
      else if (span > 64) n = $urandom_range(20, 300);
      else n = $urandom_range(span, 3 * span);
      quiet = ($urandom_range(0, 3) == 0);
      repeat (n) send_draw(rand_word(), $urandom_range(0, 4) == 0, quiet ? 0 : gap_len());
    end

    settle();
    repeat (70) @(negedge clk);
    if (fails == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// File: files.f
rtl/dwr_pkg.sv
rtl/dwr_ctrl.sv
rtl/dwr_dp.sv
rtl/draw_without_replacement.sv
dv/draw_without_replacement_checker.sv
dv/draw_without_replacement_test.sv
